// File: rtl/cz_pkg.sv
// Shared types, constants and helpers of the camera zoom/track/shake block.
package cz_pkg;

  localparam int unsigned VIEW_WIDTH_DEF  = 320;
  localparam int unsigned VIEW_HEIGHT_DEF = 224;

  localparam int OPA_W  = 32;
  localparam int OPB_W  = 17;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd32;
  localparam logic [CNT_W-1:0] MUL_STEPS = 6'd17;

  localparam logic [15:0] LCG_MUL  = 16'h4E6D;
  localparam logic [15:0] LCG_INC  = 16'h3039;
  localparam logic [15:0] LCG_SEED = 16'h1234;

  localparam logic [7:0]  ZOOM_IDX_MAX = 8'd128;
  localparam logic [15:0] BOUNDS_H_CAP = 16'd512;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_SET_POS    = 4'd1,
    ACT_MOVE       = 4'd2,
    ACT_SET_ZOOM   = 4'd3,
    ACT_SET_TARGET = 4'd4,
    ACT_SHAKE      = 4'd5,
    ACT_STOP_SHAKE = 4'd6,
    ACT_W2S        = 4'd7,
    ACT_S2W        = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    REG_ZOOM_STEP  = 3'd0,
    REG_DZ_WIDTH   = 3'd1,
    REG_DZ_HEIGHT  = 3'd2,
    REG_GAIN       = 3'd3,
    REG_BND_WIDTH  = 3'd4,
    REG_BND_HEIGHT = 3'd5,
    REG_AIM_X      = 3'd6,
    REG_AIM_Y      = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [OPA_W-1:0]  quo;
    logic [OPB_W-1:0]  rem;
    logic [PROD_W-1:0] prod;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_VW, S_VH, S_MVX, S_MULX, S_MVY, S_MULY,
    S_CLAMP, S_SHK, S_CDIV, S_MODX, S_MODY, S_S2WX, S_S2WY, S_FIN
  } seq_state_e;

  function automatic logic [7:0] level_to_index(logic [7:0] lvl);
    logic [7:0] z;
    z = lvl;
    if (z < 8'd8) z = 8'd8;
    if (z > 8'd16) z = 8'd16;
    return {z[3:0] - 4'd8, 4'b0} | {3'b0, z[4], 4'b0} << 3;
  endfunction

endpackage

// File: rtl/camera_zoom_track_shake_step.sv
// Camera zoom/track/shake engine: sequencer, camera state and result register.
// Every request yields one result. screen_to_world runs two divides; a tick with
// shake runs three divides (two when the shake length is zero), and tracking adds
// two divides and two multiplies, plus a clamp step when bounds are set. All of
// them run on the single serial unit that does every divide (32 steps) and the
// follow multiply (17 steps). tready is high only while no request is in work; a
// finished result waits in the output register until taken.
module camera_zoom_track_shake_step #(
  parameter int unsigned VIEW_WIDTH  = cz_pkg::VIEW_WIDTH_DEF,
  parameter int unsigned VIEW_HEIGHT = cz_pkg::VIEW_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, tracking_on, zoom_level, shake_strength, shake_frames
  input  logic [95:0]  s_axis_tdata_i,
  // action
  input  logic [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cam_x, cam_y, render_x, render_y, point_x, point_y, zoom_now, shrink_word,
  // zooming, shaking
  output logic [215:0] m_axis_tdata_o
);

  localparam logic [31:0] VW16 = 32'(VIEW_WIDTH * 16);
  localparam logic [31:0] VH16 = 32'(VIEW_HEIGHT * 16);

  cz_pkg::seq_state_e state_q, state_d;
  cz_pkg::alu_req_t   req;
  cz_pkg::alu_rsp_t   rsp;

  logic [5:0]  zoom_step_q;
  logic [15:0] dz_w_q, dz_h_q, bnd_w_q, bnd_h_q, aim_x_q, aim_y_q;
  logic [16:0] gain_q;

  logic [3:0]  act_q;
  logic [31:0] px_q, py_q;
  logic        trk_q;
  logic [7:0]  zlvl_q, str_q, frm_q;

  logic [31:0] pos_x_q, pos_y_q;
  logic [7:0]  zidx_q, zgoal_q, amp_q, len_q, left_q, jx_q, jy_q, c_q;
  logic [15:0] lcg_q;
  logic [16:0] vw_q, vh_q;
  logic        mvneg_q, issued_q;
  logic [31:0] mvmag_q, ptx_q, pty_q;
  logic        m_valid_q;
  logic [215:0] m_data_q;

  logic        out_free, op_state, s_acc;
  logic [4:0]  z;
  logic [8:0]  zsum;
  logic [7:0]  zdec, zidx_tick;
  logic        sel_y;
  logic [31:0] f_cam, f_act, centre, dist_v, stepv;
  logic [15:0] f_aim, f_dz, bh_cap;
  logic [16:0] f_vis;
  logic signed [32:0] dist_s, half_s, mv;
  logic [32:0] mv_abs;
  logic signed [49:0] sp;
  logic [31:0] lcg_prod;
  logic [15:0] lcg_next;
  logic [7:0]  r_next, rabs_next, jit;
  logic [8:0]  m_div;
  logic [15:0] s2w_v, s2w_abs;
  logic [31:0] ux, s2w_pt;
  logic [31:0] rx, ry, relx, rely, w2s_x, w2s_y;
  logic signed [21:0] pzx, pzy;
  logic [11:0] shrink;
  logic [7:0]  left_dec;
  logic [15:0] shk_prod;

  function automatic logic [31:0] clamp_pos(logic [31:0] cam, logic [15:0] world,
                                            logic [16:0] vis);
    logic signed [17:0] mx;
    logic [16:0] mxp;
    logic [32:0] lim;
    logic [31:0] c;
    mx  = $signed({2'b0, world}) - $signed({1'b0, vis});
    mxp = mx[17] ? '0 : mx[16:0];
    c   = cam[31] ? '0 : cam;
    lim = {mxp, 16'b0};
    return ({1'b0, c} > lim) ? lim[31:0] : c;
  endfunction

  cz_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == cz_pkg::S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    z    = 5'd8 + {1'b0, zidx_q[7:4]};
    zsum = {1'b0, zidx_q} + {3'b0, zoom_step_q};
    zdec = (zidx_q >= {2'b0, zoom_step_q}) ? zidx_q - {2'b0, zoom_step_q} : '0;
    if (zidx_q < zgoal_q) begin
      zidx_tick = (zsum > {1'b0, zgoal_q}) ? zgoal_q : zsum[7:0];
    end else if (zidx_q > zgoal_q) begin
      zidx_tick = (zdec < zgoal_q) ? zgoal_q : zdec;
    end else begin
      zidx_tick = zidx_q;
    end

    sel_y  = (state_q == cz_pkg::S_MVY) || (state_q == cz_pkg::S_MULY) ||
             (state_q == cz_pkg::S_S2WY);
    f_cam  = sel_y ? pos_y_q : pos_x_q;
    f_act  = sel_y ? py_q : px_q;
    f_aim  = sel_y ? aim_y_q : aim_x_q;
    f_vis  = sel_y ? vh_q : vw_q;
    f_dz   = sel_y ? dz_h_q : dz_w_q;
    centre = f_cam + {f_vis[16:1], 16'b0};
    dist_v = f_act + {f_aim, 16'b0} - centre;
    dist_s = $signed({dist_v[31], dist_v});
    half_s = $signed({2'b0, f_dz[15:1], 16'b0});
    if (dist_s > half_s) mv = dist_s - half_s;
    else if (dist_s < -half_s) mv = dist_s + half_s;
    else mv = '0;
    mv_abs = mv[32] ? 33'(-mv) : 33'(mv);
    sp     = $signed({1'b0, rsp.prod});
    if (mvneg_q) sp = -sp;
    stepv  = sp[47:16];

    bh_cap = (bnd_h_q > cz_pkg::BOUNDS_H_CAP) ? cz_pkg::BOUNDS_H_CAP : bnd_h_q;

    lcg_prod  = lcg_q * cz_pkg::LCG_MUL;
    lcg_next  = lcg_prod[15:0] + cz_pkg::LCG_INC;
    r_next    = lcg_next[15:8];
    rabs_next = r_next[7] ? 8'(-r_next) : r_next;
    m_div     = {c_q, 1'b1};
    jit       = (lcg_q[15] ? 8'(-rsp.rem[7:0]) : rsp.rem[7:0]) - c_q;
    left_dec  = left_q - 8'd1;
    shk_prod  = {8'b0, amp_q} * {8'b0, left_q};

    s2w_v   = sel_y ? py_q[15:0] : px_q[15:0];
    s2w_abs = s2w_v[15] ? 16'(-s2w_v) : s2w_v;
    ux      = s2w_v[15] ? 32'(-rsp.quo) : rsp.quo;
    s2w_pt  = {ux[15:0], 16'b0} + f_cam;

    rx    = pos_x_q + {{8{jx_q[7]}}, jx_q, 16'b0};
    ry    = pos_y_q + {{8{jy_q[7]}}, jy_q, 16'b0};
    relx  = px_q - rx;
    rely  = py_q - ry;
    pzx   = $signed(relx[31:16]) * $signed({1'b0, z});
    pzy   = $signed(rely[31:16]) * $signed({1'b0, z});
    w2s_x = {{16{pzx[19]}}, pzx[19:4]};
    w2s_y = {{16{pzy[19]}}, pzy[19:4]};

    shrink = 12'(({5'd0, 4'd7 + zidx_q[7:4], 4'b0} << 4) |
                 {4'b0, 9'd127 + {1'b0, zidx_q}});
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cz_pkg::S_IDLE: if (s_acc) state_d = cz_pkg::S_EXEC;
      cz_pkg::S_EXEC: begin
        priority if (act_q == cz_pkg::ACT_TICK) begin
          state_d = trk_q ? cz_pkg::S_VW : cz_pkg::S_SHK;
        end else if (act_q == cz_pkg::ACT_S2W) begin
          state_d = cz_pkg::S_S2WX;
        end else begin
          state_d = cz_pkg::S_FIN;
        end
      end
      cz_pkg::S_VW:   if (rsp.done) state_d = cz_pkg::S_VH;
      cz_pkg::S_VH:   if (rsp.done) state_d = cz_pkg::S_MVX;
      cz_pkg::S_MVX:  state_d = cz_pkg::S_MULX;
      cz_pkg::S_MULX: if (rsp.done) state_d = cz_pkg::S_MVY;
      cz_pkg::S_MVY:  state_d = cz_pkg::S_MULY;
      cz_pkg::S_MULY: begin
        if (rsp.done) begin
          state_d = (bnd_w_q != 0 || bnd_h_q != 0) ? cz_pkg::S_CLAMP : cz_pkg::S_SHK;
        end
      end
      cz_pkg::S_CLAMP: state_d = cz_pkg::S_SHK;
      cz_pkg::S_SHK: begin
        priority if (left_q == 0) state_d = cz_pkg::S_FIN;
        else if (len_q == 0) state_d = cz_pkg::S_MODX;
        else state_d = cz_pkg::S_CDIV;
      end
      cz_pkg::S_CDIV: if (rsp.done) state_d = cz_pkg::S_MODX;
      cz_pkg::S_MODX: if (rsp.done) state_d = cz_pkg::S_MODY;
      cz_pkg::S_MODY: if (rsp.done) state_d = cz_pkg::S_FIN;
      cz_pkg::S_S2WX: if (rsp.done) state_d = cz_pkg::S_S2WY;
      cz_pkg::S_S2WY: if (rsp.done) state_d = cz_pkg::S_FIN;
      cz_pkg::S_FIN:  if (out_free) state_d = cz_pkg::S_IDLE;
      default:        state_d = cz_pkg::S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    op_state = 1'b1;
    req.op   = cz_pkg::ALU_DIV;
    req.a    = '0;
    req.b    = '0;
    unique case (state_q)
      cz_pkg::S_VW: begin
        req.a = VW16;
        req.b = {12'b0, z};
      end
      cz_pkg::S_VH: begin
        req.a = VH16;
        req.b = {12'b0, z};
      end
      cz_pkg::S_MULX, cz_pkg::S_MULY: begin
        req.op = cz_pkg::ALU_MUL;
        req.a  = mvmag_q;
        req.b  = gain_q;
      end
      cz_pkg::S_CDIV: begin
        req.a = {16'b0, shk_prod};
        req.b = {9'b0, len_q};
      end
      cz_pkg::S_MODX, cz_pkg::S_MODY: begin
        req.a = {24'b0, rabs_next};
        req.b = {8'b0, m_div};
      end
      cz_pkg::S_S2WX, cz_pkg::S_S2WY: begin
        req.a = {12'b0, s2w_abs, 4'b0};
        req.b = {12'b0, z};
      end
      default: op_state = 1'b0;
    endcase
    req.start = op_state && !issued_q && !rsp.busy;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      act_q  <= s_axis_tuser_i;
      px_q   <= s_axis_tdata_i[31:0];
      py_q   <= s_axis_tdata_i[63:32];
      trk_q  <= s_axis_tdata_i[64];
      zlvl_q <= s_axis_tdata_i[72:65];
      str_q  <= s_axis_tdata_i[80:73];
      frm_q  <= s_axis_tdata_i[88:81];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_step_q <= 6'd16;
      dz_w_q      <= 16'd64;
      dz_h_q      <= 16'd32;
      gain_q      <= 17'd9830;
      bnd_w_q     <= '0;
      bnd_h_q     <= '0;
      aim_x_q     <= '0;
      aim_y_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cz_pkg::cfg_idx_e'(cfg_idx_i))
        cz_pkg::REG_ZOOM_STEP:  zoom_step_q <= cfg_data_i[5:0];
        cz_pkg::REG_DZ_WIDTH:   dz_w_q      <= cfg_data_i[15:0];
        cz_pkg::REG_DZ_HEIGHT:  dz_h_q      <= cfg_data_i[15:0];
        cz_pkg::REG_GAIN:       gain_q      <= cfg_data_i;
        cz_pkg::REG_BND_WIDTH:  bnd_w_q     <= cfg_data_i[15:0];
        cz_pkg::REG_BND_HEIGHT: bnd_h_q     <= cfg_data_i[15:0];
        cz_pkg::REG_AIM_X:      aim_x_q     <= cfg_data_i[15:0];
        cz_pkg::REG_AIM_Y:      aim_y_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cz_pkg::S_IDLE;
      issued_q  <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      zidx_q    <= cz_pkg::ZOOM_IDX_MAX;
      zgoal_q   <= cz_pkg::ZOOM_IDX_MAX;
      amp_q     <= '0;
      len_q     <= '0;
      left_q    <= '0;
      jx_q      <= '0;
      jy_q      <= '0;
      lcg_q     <= cz_pkg::LCG_SEED;
      c_q       <= '0;
      vw_q      <= '0;
      vh_q      <= '0;
      mvneg_q   <= 1'b0;
      mvmag_q   <= '0;
      ptx_q     <= '0;
      pty_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q <= state_d;
      if (req.start) issued_q <= 1'b1;
      else if (rsp.done) issued_q <= 1'b0;
      if (state_q == cz_pkg::S_FIN && out_free) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;

      unique case (state_q)
        cz_pkg::S_EXEC: begin
          ptx_q <= '0;
          pty_q <= '0;
          unique case (act_q)
            cz_pkg::ACT_TICK: zidx_q <= zidx_tick;
            cz_pkg::ACT_SET_POS: begin
              pos_x_q <= px_q;
              pos_y_q <= py_q;
            end
            cz_pkg::ACT_MOVE: begin
              pos_x_q <= pos_x_q + px_q;
              pos_y_q <= pos_y_q + py_q;
            end
            cz_pkg::ACT_SET_ZOOM: begin
              zidx_q  <= cz_pkg::level_to_index(zlvl_q);
              zgoal_q <= cz_pkg::level_to_index(zlvl_q);
            end
            cz_pkg::ACT_SET_TARGET: zgoal_q <= cz_pkg::level_to_index(zlvl_q);
            cz_pkg::ACT_SHAKE: begin
              amp_q  <= str_q;
              len_q  <= frm_q;
              left_q <= frm_q;
            end
            cz_pkg::ACT_STOP_SHAKE: begin
              left_q <= '0;
              jx_q   <= '0;
              jy_q   <= '0;
            end
            default: ;
          endcase
        end
        cz_pkg::S_VW: if (rsp.done) vw_q <= rsp.quo[16:0];
        cz_pkg::S_VH: if (rsp.done) vh_q <= rsp.quo[16:0];
        cz_pkg::S_MVX, cz_pkg::S_MVY: begin
          mvneg_q <= mv[32];
          mvmag_q <= mv_abs[31:0];
        end
        cz_pkg::S_MULX: if (rsp.done) pos_x_q <= pos_x_q + stepv;
        cz_pkg::S_MULY: if (rsp.done) pos_y_q <= pos_y_q + stepv;
        cz_pkg::S_CLAMP: begin
          pos_x_q <= clamp_pos(pos_x_q, bnd_w_q, vw_q);
          pos_y_q <= clamp_pos(pos_y_q, bh_cap, vh_q);
        end
        cz_pkg::S_SHK: begin
          if (left_q == 0) begin
            jx_q <= '0;
            jy_q <= '0;
          end else begin
            left_q <= left_dec;
            c_q    <= (left_dec != 0) ? 8'd1 : 8'd0;
          end
        end
        cz_pkg::S_CDIV: begin
          if (rsp.done) c_q <= (rsp.quo == 0 && left_q != 0) ? 8'd1 : rsp.quo[7:0];
        end
        cz_pkg::S_MODX: begin
          if (req.start) lcg_q <= lcg_next;
          if (rsp.done) jx_q <= jit;
        end
        cz_pkg::S_MODY: begin
          if (req.start) lcg_q <= lcg_next;
          if (rsp.done) jy_q <= jit;
        end
        cz_pkg::S_S2WX: if (rsp.done) ptx_q <= s2w_pt;
        cz_pkg::S_S2WY: if (rsp.done) pty_q <= s2w_pt;
        cz_pkg::S_FIN: begin
          if (out_free) begin
            m_data_q  <= {2'b0, (left_q != 0), (zidx_q != zgoal_q), shrink, zidx_q,
                          (act_q == cz_pkg::ACT_W2S) ? w2s_y : pty_q,
                          (act_q == cz_pkg::ACT_W2S) ? w2s_x : ptx_q,
                          ry, rx, pos_y_q, pos_x_q};
          end
        end
        default: ;
      endcase
    end
  end

  a_zidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zidx_q <= cz_pkg::ZOOM_IDX_MAX) else $error("zoom index out of range");

  a_zgoal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zgoal_q <= cz_pkg::ZOOM_IDX_MAX) else $error("zoom goal out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while waiting");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o) else $error("ready right after a request");

endmodule

// File: rtl/cz_alu.sv
// Shared serial unit: restoring divide or shift-add multiply, one bit per cycle.
module cz_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cz_pkg::alu_req_t req_i,
  output cz_pkg::alu_rsp_t rsp_o
);

  localparam int AW = cz_pkg::OPA_W;
  localparam int BW = cz_pkg::OPB_W;
  localparam int PW = cz_pkg::PROD_W;

  logic                     busy_q, done_q;
  cz_pkg::alu_op_e          op_q;
  logic [cz_pkg::CNT_W-1:0] cnt_q;
  logic [AW-1:0]            a_q, quo_q;
  logic [BW-1:0]            b_q, rem_q;
  logic [PW-1:0]            acc_q;

  logic [BW:0]   trial, diff;
  logic          ge;
  logic [PW-1:0] addend, mac;

  always_comb begin
    trial  = {rem_q, quo_q[AW-1]};
    ge     = trial >= {1'b0, b_q};
    diff   = trial - {1'b0, b_q};
    addend = b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0;
    mac    = {acc_q[PW-2:0], 1'b0} + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= cz_pkg::ALU_DIV;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      op_q   <= req_i.op;
      cnt_q  <= (req_i.op == cz_pkg::ALU_DIV) ? cz_pkg::DIV_STEPS : cz_pkg::MUL_STEPS;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == cz_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      quo_q <= req_i.a;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      if (op_q == cz_pkg::ALU_DIV) begin
        rem_q <= ge ? diff[BW-1:0] : trial[BW-1:0];
        quo_q <= {quo_q[AW-2:0], ge};
      end else begin
        acc_q <= mac;
        b_q   <= {b_q[BW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.prod = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("alu started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q)) else $error("alu done without run");

endmodule
